### sv/msic_pkg.sv
// ----------------------------------------------------------------------------
// msic_pkg
// Shared types and constants for the merge sort inversion counter: the input
// and result word layouts, the sequencer state codes and the saturation caps.
// ----------------------------------------------------------------------------
package msic_pkg;

	// Accumulator width; wide enough to detect passing the output cap
	localparam int TOT_W = 20;

	// Saturation caps of the result fields
	localparam logic [TOT_W-1:0] COUNT_MAX = TOT_W'(524287);
	localparam int unsigned      ITEMS_MAX = 2047;

	// One input word
	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} item_t;

	// One result word
	typedef struct packed {
		logic [18:0] inversion_count;
		logic [10:0] item_count;
		logic        overflow;
	} result_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_RUN   = 4'b0010,
		S_MERGE = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

endpackage

### sv/merge_sort_inversion_count.sv
// Sequence: words are stored one per cycle; after the last word of a set with n
// entries, ceil(log2 n) merge passes run, each reading the heads of every run
// (S_RUN) before merging it (S_MERGE); S_FLUSH then posts the result word.
// Throughput: one input word per cycle while loading; no word is taken while
// merging. The merge rate is set by the registered reads of the stores.
// Reset clears the sequencer, counts and result slot; store contents are kept.
// ----------------------------------------------------------------------------
// merge_sort_inversion_count
// Loads a sequence of 32-bit unsigned words, then merge-sorts it bottom-up
// between two ping-pong stores and counts pairs where an earlier value is
// strictly greater than a later one. Emits one result word per closed set.
// ----------------------------------------------------------------------------
module merge_sort_inversion_count
	import msic_pkg::*;
#(
	parameter int MAX_ITEMS = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int XW = CW + 2;
	localparam logic [CW-1:0] MAX_N = CW'(MAX_ITEMS);

	state_t         state_q;
	logic [CW-1:0]  fill_q;
	logic           dropped_q;
	logic [TOT_W-1:0] total_q;
	logic [CW-1:0]  width_q;
	logic [CW-1:0]  lo_q;
	logic [CW-1:0]  mid_q;
	logic [CW-1:0]  hi_q;
	logic [CW-1:0]  p_q;
	logic [CW-1:0]  q_q;
	logic [CW-1:0]  w_q;
	logic           src_q;
	result_t        result_q;
	logic           result_valid_q;

	logic           item_acc;
	logic           room;
	logic [CW-1:0]  fill_nx;
	logic [XW-1:0]  lo_x, wid_x, n_x, mid_x, hi_x, nlo_x, nw_x;
	logic [CW-1:0]  mid_c, hi_c;
	logic [31:0]    rda_a, rda_b, rdb_a, rdb_b;
	logic [31:0]    rd_p, rd_q;
	logic           p_done, q_done, take_q, run_end;
	logic [CW-1:0]  add_c;
	logic [TOT_W:0] sum_x;
	logic [CW-1:0]  raddr_p, raddr_q;
	logic           we0, we1;
	logic [CW-1:0]  waddr;
	logic [31:0]    wdata;
	logic           slot_free;

	// Handshake decode
	assign item_stall = (state_q != S_LOAD);
	assign item_acc   = item_valid && !item_stall;
	assign room       = (fill_q < MAX_N);
	assign fill_nx    = room ? fill_q + CW'(1) : fill_q;
	assign slot_free  = !result_valid_q || !result_stall;

	// Run bounds: clamp mid and hi to the set size
	assign lo_x  = XW'(lo_q);
	assign wid_x = XW'(width_q);
	assign n_x   = XW'(fill_q);
	assign mid_x = lo_x + wid_x;
	assign hi_x  = lo_x + (wid_x << 1);
	assign nlo_x = hi_x;
	assign nw_x  = wid_x << 1;
	assign mid_c = (mid_x > n_x) ? fill_q : mid_x[CW-1:0];
	assign hi_c  = (hi_x > n_x) ? fill_q : hi_x[CW-1:0];

	// Pick the heads from the source store
	assign rd_p = src_q ? rdb_a : rda_a;
	assign rd_q = src_q ? rdb_b : rda_b;

	// Merge decision; an exhausted side is never chosen
	assign p_done  = (p_q == mid_q);
	assign q_done  = (q_q == hi_q);
	assign take_q  = p_done || (!q_done && (rd_p > rd_q));
	assign run_end = (w_q == hi_q - CW'(1));
	assign add_c   = (take_q && !p_done) ? mid_q - p_q : '0;
	assign sum_x   = {1'b0, total_q} + (TOT_W + 1)'(add_c);

	// Read addresses: run heads at start, advanced heads while merging
	always_comb begin
		raddr_p = lo_q;
		raddr_q = mid_c;
		if (state_q == S_MERGE) begin
			raddr_p = take_q ? p_q : p_q + CW'(1);
			raddr_q = take_q ? q_q + CW'(1) : q_q;
		end
	end

	// Write routing: loading fills store 0, merging writes the other store
	always_comb begin
		we0   = 1'b0;
		we1   = 1'b0;
		waddr = fill_q;
		wdata = item.value;
		if (state_q == S_MERGE) begin
			waddr = w_q;
			wdata = take_q ? rd_q : rd_p;
			we0   = src_q;
			we1   = !src_q;
		end else if (item_acc && room) begin
			we0 = 1'b1;
		end
	end

	msic_ram #(.DEPTH(MAX_ITEMS)) u_ram0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr[AW-1:0]),
		.wdata   (wdata),
		.raddr_a (raddr_p[AW-1:0]),
		.raddr_b (raddr_q[AW-1:0]),
		.rdata_a (rda_a),
		.rdata_b (rda_b)
	);

	msic_ram #(.DEPTH(MAX_ITEMS)) u_ram1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr[AW-1:0]),
		.wdata   (wdata),
		.raddr_a (raddr_p[AW-1:0]),
		.raddr_b (raddr_q[AW-1:0]),
		.rdata_a (rdb_a),
		.rdata_b (rdb_b)
	);

	// Sequencer: load, run start, merge, post result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			fill_q         <= '0;
			dropped_q      <= 1'b0;
			total_q        <= '0;
			width_q        <= '0;
			lo_q           <= '0;
			src_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// Drop the result word once taken; the flush state posts the next one
			if (result_valid_q && !result_stall && state_q != S_FLUSH) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (item_acc) begin
						fill_q <= fill_nx;
						if (!room) begin
							dropped_q <= 1'b1;
						end
						if (item.last) begin
							width_q <= CW'(1);
							lo_q    <= '0;
							src_q   <= 1'b0;
							total_q <= '0;
							state_q <= (fill_nx > CW'(1)) ? S_RUN : S_FLUSH;
						end
					end
				end
				S_RUN: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					total_q <= sum_x[TOT_W] ? '1 : sum_x[TOT_W-1:0];
					if (run_end) begin
						if (nlo_x >= n_x) begin
							width_q <= nw_x[CW-1:0];
							lo_q    <= '0;
							src_q   <= !src_q;
							state_q <= (nw_x >= n_x) ? S_FLUSH : S_RUN;
						end else begin
							lo_q    <= nlo_x[CW-1:0];
							state_q <= S_RUN;
						end
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						result_valid_q <= 1'b1;
						fill_q         <= '0;
						dropped_q      <= 1'b0;
						total_q        <= '0;
						state_q        <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Run pointers
	always_ff @(posedge clk) begin
		if (state_q == S_RUN) begin
			p_q   <= lo_q;
			q_q   <= mid_c;
			w_q   <= lo_q;
			mid_q <= mid_c;
			hi_q  <= hi_c;
		end else if (state_q == S_MERGE) begin
			p_q <= take_q ? p_q : p_q + CW'(1);
			q_q <= take_q ? q_q + CW'(1) : q_q;
			w_q <= w_q + CW'(1);
		end
	end

	// Result word, saturated
	always_ff @(posedge clk) begin
		if (state_q == S_FLUSH && slot_free) begin
			result_q.inversion_count <= (total_q > COUNT_MAX) ? 19'h7FFFF : 19'(total_q);
			result_q.item_count      <= (32'(fill_q) > ITEMS_MAX) ? 11'h7FF : 11'(fill_q);
			result_q.overflow        <= dropped_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_N)
		else $error("fill count beyond capacity");

	a_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> w_q < hi_q)
		else $error("merge write outside its run");

	a_heads_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> (p_q <= mid_q && q_q <= hi_q && !(p_done && q_done)))
		else $error("merge heads outside their halves");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |=> total_q >= $past(total_q))
		else $error("inversion total fell while merging");
`endif

endmodule

### sv/msic_ram.sv
// ----------------------------------------------------------------------------
// msic_ram
// Element store: one write port and two read ports, read data registered,
// so a read returns its entry in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module msic_ram #(
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [31:0]   rdata_a,
	output logic [31:0]   rdata_b
);

	logic [31:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read two entries, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
